[rtl/string_hash_varying_multiplier_unit_assert.svh]
// Assertion macros for the string hash unit.
// Included by files that carry concurrent checks; depends on nothing.
`ifndef STRING_HASH_VARYING_MULTIPLIER_UNIT_ASSERT_SVH
`define STRING_HASH_VARYING_MULTIPLIER_UNIT_ASSERT_SVH

// same-cycle implication
`define SHVM_ASSERT_IMP(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("shvm check failed");

// next-cycle implication
`define SHVM_ASSERT_NXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("shvm check failed");

`endif

[rtl/shvm_pkg.sv]
// Package for the string hash unit: field widths, hash constants, step codes
// and the microcode table. Depends on nothing.
package shvm_pkg;

   localparam int CH_WIDTH   = 8;
   localparam int HASH_WIDTH = 24;
   localparam int TS_WIDTH   = 25;

   localparam int unsigned HASH_SEED        = 31415;
   localparam int unsigned HASH_STEP        = 27183;
   localparam int unsigned SEED_WIDTH       = 15;
   localparam int unsigned TABLE_SIZE_RESET = 11;
   localparam int unsigned MOD_MIN          = 2;

   localparam int PC_WIDTH = 3;

   // microprogram step addresses
   localparam logic [PC_WIDTH-1:0] P_IDLE   = 3'd0;
   localparam logic [PC_WIDTH-1:0] P_NLOAD  = 3'd1;
   localparam logic [PC_WIDTH-1:0] P_NLOOP  = 3'd2;
   localparam logic [PC_WIDTH-1:0] P_NSTORE = 3'd3;
   localparam logic [PC_WIDTH-1:0] P_MLOAD  = 3'd4;
   localparam logic [PC_WIDTH-1:0] P_MLOOP  = 3'd5;
   localparam logic [PC_WIDTH-1:0] P_FOLD   = 3'd6;
   localparam logic [PC_WIDTH-1:0] P_EMIT   = 3'd7;

   // sequencer jump kinds
   localparam logic [2:0] J_NEXT     = 3'd0;
   localparam logic [2:0] J_GOTO     = 3'd1;
   localparam logic [2:0] J_LOOP     = 3'd2;
   localparam logic [2:0] J_LAST     = 3'd3;
   localparam logic [2:0] J_DISPATCH = 3'd4;
   localparam logic [2:0] J_EMIT     = 3'd5;

   typedef struct packed {
      logic                accept;
      logic                load_norm;
      logic                load_mul;
      logic                step;
      logic                mul;
      logic                store_norm;
      logic                fold;
      logic                emit;
      logic [2:0]          jump;
      logic [PC_WIDTH-1:0] target;
   } ctrl_word_type;

   function automatic ctrl_word_type ucode_rom(input logic [PC_WIDTH-1:0] pc);
      ctrl_word_type w;
      w = '0;
      case (pc)
         P_IDLE: begin
            w.accept = 1'b1;
            w.jump   = J_DISPATCH;
            w.target = P_IDLE;
         end
         P_NLOAD: begin
            w.load_norm = 1'b1;
            w.jump      = J_NEXT;
         end
         P_NLOOP: begin
            w.step   = 1'b1;
            w.jump   = J_LOOP;
            w.target = P_NLOOP;
         end
         P_NSTORE: begin
            w.store_norm = 1'b1;
            w.jump       = J_NEXT;
         end
         P_MLOAD: begin
            w.load_mul = 1'b1;
            w.jump     = J_NEXT;
         end
         P_MLOOP: begin
            w.step   = 1'b1;
            w.mul    = 1'b1;
            w.jump   = J_LOOP;
            w.target = P_MLOOP;
         end
         P_FOLD: begin
            w.fold   = 1'b1;
            w.jump   = J_LAST;
            w.target = P_IDLE;
         end
         P_EMIT: begin
            w.emit   = 1'b1;
            w.jump   = J_EMIT;
            w.target = P_IDLE;
         end
         default: begin
            w.jump   = J_GOTO;
            w.target = P_IDLE;
         end
      endcase
      return w;
   endfunction

endpackage

[rtl/shvm_if.sv]
// Valid/ready channel interfaces for the string hash unit: request,
// response and register write. Depends on shvm_pkg for field widths.
interface shvm_req_if import shvm_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [CH_WIDTH-1:0] ch;
   logic                last;
   logic                is_empty;

   modport source (output valid, output ch, output last, output is_empty, input ready);
   modport sink (input valid, input ch, input last, input is_empty, output ready);
endinterface

interface shvm_rsp_if import shvm_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [HASH_WIDTH-1:0] hash_value;

   modport source (output valid, output hash_value, input ready);
   modport sink (input valid, input hash_value, output ready);
endinterface

interface shvm_csr_if import shvm_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [TS_WIDTH-1:0] data;

   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

[rtl/shvm_modstep.sv]
// One step of a radix-2 modular multiply or reduce: (2r or r) + addend,
// brought back below the modulus. Standalone, no package dependency.
module shvm_modstep #(
   parameter int W = 24
) (
   input  logic [W-1:0] r,
   input  logic [W-1:0] addend,
   input  logic [W:0]   modulus,
   input  logic         dbl,
   output logic [W-1:0] r_next
);

   logic [W+1:0] t;
   logic [W+1:0] m1;
   logic [W+1:0] m2;
   logic [W+1:0] d1;
   logic [W+1:0] d2;

   always_comb begin
      t  = (dbl ? {1'b0, r, 1'b0} : (W+2)'(r)) + (W+2)'(addend);
      m1 = (W+2)'(modulus);
      m2 = {modulus, 1'b0};
      d1 = t - m1;
      d2 = t - m2;
      if (t >= m2) begin
         r_next = d2[W-1:0];
      end else if (t >= m1) begin
         r_next = d1[W-1:0];
      end else begin
         r_next = t[W-1:0];
      end
   end

endmodule

[rtl/string_hash_varying_multiplier_unit.sv]
// String hash with a varying multiplier, run by a microcoded sequencer.
// An inner character runs the LW-step radix-2 modular loop, LW = max(SIZE_WIDTH, 15)
// (24 at 24), shared by accumulator, multiplier and character, then a fold step.
// The first character of a string, or one after a table_size write, first reduces
// the operands (load, loop, store); the last adds an emit step, result registered.
// An empty item goes to emit with hash zero. Synchronous reset restores table_size 11.
`include "string_hash_varying_multiplier_unit_assert.svh"

module string_hash_varying_multiplier_unit import shvm_pkg::*; #(
   parameter int SIZE_WIDTH = 24
) (
   input logic         clock,
   input logic         reset,
   shvm_req_if.sink    req_bus,
   shvm_rsp_if.source  rsp_bus,
   shvm_csr_if.sink    csr_bus
);

   localparam int LW    = (SIZE_WIDTH > SEED_WIDTH) ? SIZE_WIDTH : SEED_WIDTH;
   localparam int CNT_W = $clog2(LW);
   localparam int CMP_W = (TS_WIDTH > SIZE_WIDTH + 1) ? TS_WIDTH : SIZE_WIDTH + 1;
   localparam logic [CNT_W-1:0]    LAST_CNT = CNT_W'(LW - 1);
   localparam logic [SIZE_WIDTH:0] MOD_MAX  = {1'b1, {SIZE_WIDTH{1'b0}}};

   ctrl_word_type cw;

   logic [PC_WIDTH-1:0]   pc_ff, pc_in;
   logic                  need_norm_ff, need_norm_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [HASH_WIDTH-1:0] rsp_hash_ff, rsp_hash_in;
   logic [SIZE_WIDTH-1:0] acc_ff, acc_in;
   logic [LW-1:0]         mult_ff, mult_in;
   logic [SIZE_WIDTH-1:0] amul_ff, amul_in;
   logic [SIZE_WIDTH:0]   mod_ff, mod_in;
   logic [SIZE_WIDTH:0]   mod1_ff, mod1_in;
   logic [LW-1:0]         sa_ff, sa_in;
   logic [LW-1:0]         sb_ff, sb_in;
   logic [LW-1:0]         sc_ff, sc_in;
   logic [SIZE_WIDTH-1:0] ra_ff, ra_in;
   logic [SIZE_WIDTH-1:0] rb_ff, rb_in;
   logic [SIZE_WIDTH-1:0] rc_ff, rc_in;
   logic [CNT_W-1:0]      cnt_ff, cnt_in;
   logic [CH_WIDTH-1:0]   ch_ff, ch_in;
   logic                  last_ff, last_in;
   logic                  empty_ff, empty_in;

   logic req_xfer;
   logic csr_xfer;
   logic out_busy;

   logic [SIZE_WIDTH-1:0] a_add, b_add, c_add;
   logic [SIZE_WIDTH-1:0] a_next, b_next, c_next;
   logic                  a_dbl;
   logic [SIZE_WIDTH+HASH_WIDTH-1:0] acc_wide;
   logic [CMP_W-1:0] ts_ext, max_ext, clamp_ext;

   assign cw        = ucode_rom(pc_ff);
   assign req_xfer  = req_bus.valid & req_bus.ready;
   assign csr_xfer  = csr_bus.valid & csr_bus.ready;
   assign out_busy  = rsp_valid_ff & ~rsp_bus.ready;
   assign acc_wide  = {{HASH_WIDTH{1'b0}}, acc_ff};

   assign req_bus.ready      = cw.accept;
   assign csr_bus.ready      = (pc_ff == P_IDLE);
   assign rsp_bus.valid      = rsp_valid_ff;
   assign rsp_bus.hash_value = rsp_hash_ff;

   always_comb begin
      a_dbl = ~cw.fold;
      if (cw.fold) begin
         a_add = rc_ff;
      end else if (sa_ff[LW-1]) begin
         a_add = cw.mul ? amul_ff : SIZE_WIDTH'(1);
      end else begin
         a_add = '0;
      end
      if (sb_ff[LW-1]) begin
         b_add = cw.mul ? mult_ff[SIZE_WIDTH-1:0] : SIZE_WIDTH'(1);
      end else begin
         b_add = '0;
      end
      c_add = SIZE_WIDTH'(sc_ff[LW-1]);
   end

   shvm_modstep #(.W(SIZE_WIDTH)) u_acc (
      .r(ra_ff), .addend(a_add), .modulus(mod_ff), .dbl(a_dbl), .r_next(a_next)
   );

   shvm_modstep #(.W(SIZE_WIDTH)) u_mult (
      .r(rb_ff), .addend(b_add), .modulus(mod1_ff), .dbl(1'b1), .r_next(b_next)
   );

   shvm_modstep #(.W(SIZE_WIDTH)) u_char (
      .r(rc_ff), .addend(c_add), .modulus(mod_ff), .dbl(1'b1), .r_next(c_next)
   );

   always_comb begin
      ts_ext  = CMP_W'(csr_bus.data);
      max_ext = CMP_W'(MOD_MAX);
      if (ts_ext < CMP_W'(MOD_MIN)) begin
         clamp_ext = CMP_W'(MOD_MIN);
      end else if (ts_ext > max_ext) begin
         clamp_ext = max_ext;
      end else begin
         clamp_ext = ts_ext;
      end
   end

   always_comb begin
      need_norm_in = need_norm_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_hash_in  = rsp_hash_ff;
      acc_in       = acc_ff;
      mult_in      = mult_ff;
      amul_in      = amul_ff;
      mod_in       = mod_ff;
      mod1_in      = mod1_ff;
      sa_in        = sa_ff;
      sb_in        = sb_ff;
      sc_in        = sc_ff;
      ra_in        = ra_ff;
      rb_in        = rb_ff;
      rc_in        = rc_ff;
      cnt_in       = cnt_ff;
      ch_in        = ch_ff;
      last_in      = last_ff;
      empty_in     = empty_ff;

      if (req_xfer) begin
         ch_in    = req_bus.ch;
         last_in  = req_bus.last;
         empty_in = req_bus.is_empty;
      end
      if (cw.load_norm) begin
         sa_in  = LW'(acc_ff);
         sb_in  = mult_ff;
         sc_in  = mult_ff;
         ra_in  = '0;
         rb_in  = '0;
         rc_in  = '0;
         cnt_in = LAST_CNT;
      end
      if (cw.load_mul) begin
         sa_in  = LW'(acc_ff);
         sb_in  = LW'(HASH_STEP);
         sc_in  = LW'(ch_ff);
         ra_in  = '0;
         rb_in  = '0;
         rc_in  = '0;
         cnt_in = LAST_CNT;
      end
      if (cw.step) begin
         ra_in  = a_next;
         rb_in  = b_next;
         rc_in  = c_next;
         sa_in  = {sa_ff[LW-2:0], 1'b0};
         sb_in  = {sb_ff[LW-2:0], 1'b0};
         sc_in  = {sc_ff[LW-2:0], 1'b0};
         cnt_in = cnt_ff - CNT_W'(1);
      end
      if (cw.store_norm) begin
         acc_in       = ra_ff;
         mult_in      = LW'(rb_ff);
         amul_in      = rc_ff;
         need_norm_in = 1'b0;
      end
      if (cw.fold) begin
         acc_in  = a_next;
         mult_in = LW'(rb_ff);
         amul_in = rb_ff;
      end
      if (rsp_valid_ff && rsp_bus.ready) begin
         rsp_valid_in = 1'b0;
      end
      if (cw.emit && !out_busy) begin
         rsp_valid_in = 1'b1;
         rsp_hash_in  = empty_ff ? '0 : acc_wide[HASH_WIDTH-1:0];
         acc_in       = '0;
         mult_in      = LW'(HASH_SEED);
         need_norm_in = 1'b1;
      end
      if (csr_xfer) begin
         mod_in       = clamp_ext[SIZE_WIDTH:0];
         mod1_in      = clamp_ext[SIZE_WIDTH:0] - (SIZE_WIDTH+1)'(1);
         need_norm_in = 1'b1;
      end
   end

   always_comb begin
      case (cw.jump)
         J_NEXT: begin
            pc_in = pc_ff + PC_WIDTH'(1);
         end
         J_GOTO: begin
            pc_in = cw.target;
         end
         J_LOOP: begin
            pc_in = (cnt_ff == '0) ? pc_ff + PC_WIDTH'(1) : cw.target;
         end
         J_LAST: begin
            pc_in = last_ff ? pc_ff + PC_WIDTH'(1) : cw.target;
         end
         J_DISPATCH: begin
            if (!req_xfer) begin
               pc_in = cw.target;
            end else if (req_bus.is_empty) begin
               pc_in = P_EMIT;
            end else if (need_norm_ff || csr_xfer) begin
               pc_in = P_NLOAD;
            end else begin
               pc_in = P_MLOAD;
            end
         end
         J_EMIT: begin
            pc_in = out_busy ? pc_ff : cw.target;
         end
         default: begin
            pc_in = P_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff        <= P_IDLE;
         need_norm_ff <= 1'b1;
         rsp_valid_ff <= 1'b0;
         acc_ff       <= '0;
         mult_ff      <= LW'(HASH_SEED);
         amul_ff      <= '0;
         mod_ff       <= (SIZE_WIDTH+1)'(TABLE_SIZE_RESET);
         mod1_ff      <= (SIZE_WIDTH+1)'(TABLE_SIZE_RESET - 1);
      end else begin
         pc_ff        <= pc_in;
         need_norm_ff <= need_norm_in;
         rsp_valid_ff <= rsp_valid_in;
         acc_ff       <= acc_in;
         mult_ff      <= mult_in;
         amul_ff      <= amul_in;
         mod_ff       <= mod_in;
         mod1_ff      <= mod1_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_hash_ff <= rsp_hash_in;
      sa_ff       <= sa_in;
      sb_ff       <= sb_in;
      sc_ff       <= sc_in;
      ra_ff       <= ra_in;
      rb_ff       <= rb_in;
      rc_ff       <= rc_in;
      cnt_ff      <= cnt_in;
      ch_ff       <= ch_in;
      last_ff     <= last_in;
      empty_ff    <= empty_in;
   end

   `SHVM_ASSERT_IMP(a_acc_reduced, clock, reset, (pc_ff == P_IDLE) && !need_norm_ff, ({1'b0, acc_ff} < mod_ff))
   `SHVM_ASSERT_IMP(a_mult_reduced, clock, reset, (pc_ff == P_IDLE) && !need_norm_ff, (mult_ff < mod1_ff))
   `SHVM_ASSERT_IMP(a_char_reduced, clock, reset, (pc_ff == P_FOLD), ({1'b0, rc_ff} < mod_ff))
   `SHVM_ASSERT_NXT(a_emit_restarts, clock, reset, (pc_ff == P_EMIT) && !out_busy, rsp_valid_ff && need_norm_ff && (pc_ff == P_IDLE))

endmodule
